@@ src/battery_level_averager_assert.svh @@
// ----------------------------------------------------------------------------
// Battery level averager assertion macros
// Shorthand for the concurrent checks of the battery gauge datapath.
// ----------------------------------------------------------------------------
`ifndef BATTERY_LEVEL_AVERAGER_ASSERT_SVH
`define BATTERY_LEVEL_AVERAGER_ASSERT_SVH

// Check that a condition implies a consequence in the same cycle.
`define BLA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("battery_level_averager: same-cycle check failed");

// Check that a condition implies a consequence in the next cycle.
`define BLA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("battery_level_averager: next-cycle check failed");

`endif

@@ src/bla_pkg.sv @@
// ----------------------------------------------------------------------------
// Battery level averager package
// Shared widths, constants, register indexes and divider handshake types.
// ----------------------------------------------------------------------------
package bla_pkg;

   // Default ring depth
   localparam int RING_DEPTH_DEF = 10;

   // Field widths
   localparam int SAMPLE_W = 12;
   localparam int PIN_W    = 12;
   localparam int MV_W     = 16;
   localparam int PCT_W    = 7;
   localparam int OHM_W    = 20;
   localparam int CSR_IDX_W = 2;

   // Conversion constants
   localparam int ADC_FULL_SCALE = 4095;
   localparam int PIN_FULL_MV    = 3300;
   localparam int PCT_FULL       = 100;
   localparam logic [MV_W-1:0] MV_SATURATE = '1;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DIV_TOP    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DIV_BOTTOM = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_EMPTY_MV   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FULL_MV    = 2'd3;

   // Configuration reset values
   localparam logic [OHM_W-1:0] DIV_TOP_RST    = 20'd100000;
   localparam logic [OHM_W-1:0] DIV_BOTTOM_RST = 20'd100000;
   localparam logic [MV_W-1:0]  EMPTY_MV_RST   = 16'd3300;
   localparam logic [MV_W-1:0]  FULL_MV_RST    = 16'd4200;

   // Serial divider sizing: widest dividend is the rounded divider scaling
   localparam int DVD_W = 34;
   localparam int DIV_W = OHM_W + 1;
   localparam int NB_W  = $clog2(DVD_W + 1);

   // Product widths ahead of the divider
   localparam int PIN_PROD_W = 24;
   localparam int BAT_PROD_W = 33;
   localparam int PCT_PROD_W = 23;

   // Divider start request
   typedef struct packed {
      logic             start;
      logic [DVD_W-1:0] dividend;
      logic [DIV_W-1:0] divisor;
      logic [NB_W-1:0]  nbits;
   } div_req_type;

   // Divider status and result
   typedef struct packed {
      logic             busy;
      logic             done;
      logic [DVD_W-1:0] quotient;
   } div_rsp_type;

endpackage

@@ src/bla_ring.sv @@
// ----------------------------------------------------------------------------
// Battery level averager sample ring
// Holds recent samples, their running sum and the count of nonzero entries.
// ----------------------------------------------------------------------------
module bla_ring #(
   parameter int RING_DEPTH = bla_pkg::RING_DEPTH_DEF,
   parameter int SUM_W      = bla_pkg::SAMPLE_W + $clog2(RING_DEPTH),
   parameter int CNT_W      = $clog2(RING_DEPTH + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  logic [bla_pkg::SAMPLE_W-1:0]  sample,
   output logic [SUM_W-1:0]              sum,
   output logic [CNT_W-1:0]              count
);
   import bla_pkg::*;

   localparam int SLOT_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(RING_DEPTH - 1);

   logic [SAMPLE_W-1:0] ring_ff [RING_DEPTH];
   logic [SLOT_W-1:0]   slot_ff, slot_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [SAMPLE_W-1:0] old_sample;

   // Replace the oldest entry and update the running totals
   always_comb begin
      old_sample = ring_ff[slot_ff];
      sum_in     = sum_ff - SUM_W'(old_sample) + SUM_W'(sample);
      count_in   = count_ff - CNT_W'(old_sample != '0) + CNT_W'(sample != '0);
      slot_in    = (slot_ff == SLOT_LAST) ? '0 : slot_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < RING_DEPTH; i++) begin
            ring_ff[i] <= '0;
         end
         slot_ff  <= '0;
         sum_ff   <= '0;
         count_ff <= '0;
      end else if (push) begin
         ring_ff[slot_ff] <= sample;
         slot_ff          <= slot_in;
         sum_ff           <= sum_in;
         count_ff         <= count_in;
      end
   end

   assign sum   = sum_ff;
   assign count = count_ff;

endmodule

@@ src/bla_div.sv @@
// ----------------------------------------------------------------------------
// Battery level averager serial divider
// Restoring divider that retires one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bla_div (
   input  logic                  clock,
   input  logic                  reset,
   input  bla_pkg::div_req_type  req,
   output bla_pkg::div_rsp_type  rsp
);
   import bla_pkg::*;

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [NB_W-1:0]  cnt_ff, cnt_in;
   logic [DVD_W-1:0] dvd_ff, dvd_in;
   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [DIV_W-1:0] dvs_ff, dvs_in;
   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [DIV_W:0]   trial;
   logic [DIV_W:0]   diff;
   logic             qbit;

   // Shift in the next dividend bit and try one subtraction
   always_comb begin
      trial = {rem_ff, dvd_ff[DVD_W-1]};
      diff  = trial - {1'b0, dvs_ff};
      qbit  = (trial >= {1'b0, dvs_ff});

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;

      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = req.nbits;
         dvd_in  = req.dividend;
         dvs_in  = req.divisor;
         quo_in  = '0;
         rem_in  = '0;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[DVD_W-2:0], 1'b0};
         quo_in = {quo_ff[DVD_W-2:0], qbit};
         rem_in = qbit ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == NB_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
   end

   assign rsp.busy     = busy_ff;
   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

@@ src/battery_level_averager.sv @@
// ----------------------------------------------------------------------------
// Battery level averager
// Moving-average battery gauge: ring average, pin and battery millivolts, and
// charge percentage, all divisions done on one shared bit-serial divider.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one raw ADC sample per transfer; rsp_* returns one result
//   per sample. csr_* writes the divider resistors and the empty/full limits;
//   the user must write them only while the block is idle, as the block
//   itself does not enforce it. The block works on one sample at a time.
//   req_tready is high only while the sequencer is idle. Each sample runs up
//   to four divisions of 16/SUM_W, 24, 34 and 23 quotient bits on the shared
//   serial divider. Divisions that are not needed (empty ring, zero bottom
//   resistor, clamped percentage) are skipped; the pin division always runs.
//   A new sample is taken once the sequencer has loaded the result into the
//   output register and returned to idle.
//   A result that the receiver stalls waits in the output register; the next
//   sample is still taken and processed, and its result waits in the
//   sequencer until the output register frees up.
//   Reset clears the sample ring, the running totals, the configuration
//   registers to their defaults and both channels.
// ----------------------------------------------------------------------------
`include "battery_level_averager_assert.svh"

module battery_level_averager #(
   parameter int RING_DEPTH = bla_pkg::RING_DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // req_tdata: [11:0] raw_sample, [15:12] zero
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [15:0]                     req_tdata,
   // rsp_tdata: [11:0] average_raw, [23:12] pin_mv, [39:24] vbat_mv,
   //            [46:40] percent, [47] zero
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [47:0]                     rsp_tdata,
   input  logic                            csr_we,
   input  logic [bla_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bla_pkg::OHM_W-1:0]       csr_wdata
);
   import bla_pkg::*;

   localparam int SUM_W = SAMPLE_W + $clog2(RING_DEPTH);
   localparam int CNT_W = $clog2(RING_DEPTH + 1);

   // Sequencer states
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_AVG   = 4'd1;
   localparam logic [3:0] S_AVG_W = 4'd2;
   localparam logic [3:0] S_PIN   = 4'd3;
   localparam logic [3:0] S_PIN_W = 4'd4;
   localparam logic [3:0] S_BAT   = 4'd5;
   localparam logic [3:0] S_BAT_W = 4'd6;
   localparam logic [3:0] S_PCT   = 4'd7;
   localparam logic [3:0] S_PCT_W = 4'd8;
   localparam logic [3:0] S_OUT   = 4'd9;

   logic                push;
   logic [SUM_W-1:0]    sum;
   logic [CNT_W-1:0]    count;
   div_req_type         div_req;
   div_rsp_type         div_rsp;

   logic [3:0]          state_ff, state_in;
   logic                div_wait;
   logic [OHM_W-1:0]    div_top_ff, div_bottom_ff;
   logic [MV_W-1:0]     empty_mv_ff, full_mv_ff;
   logic [SAMPLE_W-1:0] avg_ff, avg_in;
   logic [PIN_W-1:0]    pin_ff, pin_in;
   logic [MV_W-1:0]     bat_ff, bat_in;
   logic [PCT_W-1:0]    pct_ff, pct_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_load;
   logic [SAMPLE_W-1:0] rsp_avg_ff;
   logic [PIN_W-1:0]    rsp_pin_ff;
   logic [MV_W-1:0]     rsp_bat_ff;
   logic [PCT_W-1:0]    rsp_pct_ff;

   logic [PIN_PROD_W-1:0] pin_prod;
   logic [OHM_W:0]        ratio_sum;
   logic [BAT_PROD_W-1:0] bat_prod;
   logic [MV_W-1:0]       bat_over_empty;
   logic [PCT_PROD_W-1:0] pct_prod;

   // Ring of recent samples with running sum and nonzero count
   bla_ring #(
      .RING_DEPTH (RING_DEPTH),
      .SUM_W      (SUM_W),
      .CNT_W      (CNT_W)
   ) u_ring (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .sample (req_tdata[SAMPLE_W-1:0]),
      .sum    (sum),
      .count  (count)
   );

   // Shared serial divider
   bla_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign push       = req_tvalid && req_tready;

   // Divider results are consumed only in the wait states
   assign div_wait = (state_ff inside {S_AVG_W, S_PIN_W, S_BAT_W, S_PCT_W});

   // Hold configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         div_top_ff    <= DIV_TOP_RST;
         div_bottom_ff <= DIV_BOTTOM_RST;
         empty_mv_ff   <= EMPTY_MV_RST;
         full_mv_ff    <= FULL_MV_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_DIV_TOP:    div_top_ff    <= csr_wdata;
            CSR_DIV_BOTTOM: div_bottom_ff <= csr_wdata;
            CSR_EMPTY_MV:   empty_mv_ff   <= csr_wdata[MV_W-1:0];
            CSR_FULL_MV:    full_mv_ff    <= csr_wdata[MV_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Products feeding the divider, one multiplier per operand pair
   always_comb begin
      pin_prod       = PIN_PROD_W'(avg_ff) * PIN_PROD_W'(PIN_FULL_MV);
      ratio_sum      = {1'b0, div_top_ff} + {1'b0, div_bottom_ff};
      bat_prod       = BAT_PROD_W'(pin_ff) * BAT_PROD_W'(ratio_sum);
      bat_over_empty = bat_ff - empty_mv_ff;
      pct_prod       = PCT_PROD_W'(bat_over_empty) * PCT_PROD_W'(PCT_FULL);
   end

   // Sequence the four conversion steps
   always_comb begin
      state_in = state_ff;
      avg_in   = avg_ff;
      pin_in   = pin_ff;
      bat_in   = bat_ff;
      pct_in   = pct_ff;
      rsp_load = 1'b0;

      div_req.start    = 1'b0;
      div_req.dividend = '0;
      div_req.divisor  = '0;
      div_req.nbits    = '0;

      case (state_ff)
         S_IDLE: begin
            if (push) begin
               state_in = S_AVG;
            end
         end
         S_AVG: begin
            if (count == '0) begin
               avg_in   = '0;
               state_in = S_PIN;
            end else begin
               div_req.start    = 1'b1;
               div_req.dividend = {sum, {(DVD_W - SUM_W){1'b0}}};
               div_req.divisor  = DIV_W'(count);
               div_req.nbits    = NB_W'(SUM_W);
               state_in         = S_AVG_W;
            end
         end
         S_AVG_W: begin
            if (div_rsp.done) begin
               avg_in   = div_rsp.quotient[SAMPLE_W-1:0];
               state_in = S_PIN;
            end
         end
         S_PIN: begin
            div_req.start    = 1'b1;
            div_req.dividend = {pin_prod, {(DVD_W - PIN_PROD_W){1'b0}}};
            div_req.divisor  = DIV_W'(ADC_FULL_SCALE);
            div_req.nbits    = NB_W'(PIN_PROD_W);
            state_in         = S_PIN_W;
         end
         S_PIN_W: begin
            if (div_rsp.done) begin
               pin_in   = div_rsp.quotient[PIN_W-1:0];
               state_in = S_BAT;
            end
         end
         S_BAT: begin
            // Zero bottom resistor saturates any nonzero pin voltage
            if (div_bottom_ff == '0) begin
               bat_in   = (pin_ff != '0) ? MV_SATURATE : '0;
               state_in = S_PCT;
            end else begin
               div_req.start    = 1'b1;
               div_req.dividend = {bat_prod, 1'b0} + DVD_W'(div_bottom_ff);
               div_req.divisor  = {div_bottom_ff, 1'b0};
               div_req.nbits    = NB_W'(DVD_W);
               state_in         = S_BAT_W;
            end
         end
         S_BAT_W: begin
            if (div_rsp.done) begin
               bat_in = (div_rsp.quotient[DVD_W-1:MV_W] != '0) ?
                        MV_SATURATE : div_rsp.quotient[MV_W-1:0];
               state_in = S_PCT;
            end
         end
         S_PCT: begin
            // Clamp at the limits, empty checked first
            if (bat_ff <= empty_mv_ff) begin
               pct_in   = '0;
               state_in = S_OUT;
            end else if (bat_ff >= full_mv_ff) begin
               pct_in   = PCT_W'(PCT_FULL);
               state_in = S_OUT;
            end else begin
               div_req.start    = 1'b1;
               div_req.dividend = {pct_prod, {(DVD_W - PCT_PROD_W){1'b0}}};
               div_req.divisor  = DIV_W'(full_mv_ff - empty_mv_ff);
               div_req.nbits    = NB_W'(PCT_PROD_W);
               state_in         = S_PCT_W;
            end
         end
         S_PCT_W: begin
            if (div_rsp.done) begin
               pct_in   = div_rsp.quotient[PCT_W-1:0];
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Output register: load a finished result, drop it on transfer
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      avg_ff <= avg_in;
      pin_ff <= pin_in;
      bat_ff <= bat_in;
      pct_ff <= pct_in;
      if (rsp_load) begin
         rsp_avg_ff <= avg_ff;
         rsp_pin_ff <= pin_ff;
         rsp_bat_ff <= bat_ff;
         rsp_pct_ff <= pct_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_pct_ff, rsp_bat_ff, rsp_pin_ff, rsp_avg_ff};

   // Checks
   `BLA_ASSERT_NEXT(a_accept_starts_avg, clock, reset, push, state_ff == S_AVG)
   `BLA_ASSERT_NOW(a_done_in_wait, clock, reset, div_rsp.done, div_wait)
   `BLA_ASSERT_NOW(a_start_when_free, clock, reset, div_req.start, !div_rsp.busy)
   `BLA_ASSERT_NOW(a_count_range, clock, reset, 1'b1, count <= CNT_W'(RING_DEPTH))
   `BLA_ASSERT_NOW(a_pct_range, clock, reset, rsp_valid_ff, rsp_pct_ff <= PCT_W'(PCT_FULL))

endmodule
